>>> design/dma_tx_ring_buffer_assert.svh
// Assertion macros used by the ring buffer control module.
`ifndef DMA_TX_RING_BUFFER_ASSERT_SVH
`define DMA_TX_RING_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS
`define DTRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTRB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DTRB_ASSERT(lbl, prop, msg)
`define DTRB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> design/dtrb_pkg.sv
// Types and constants of the transmit DMA ring buffer.
package dtrb_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_DONE  = 2'd2;

  localparam logic [3:0] LENGTH_LOG2_RESET = 4'd10;
  localparam logic [9:0] BLOCK_COUNT_MAX   = 10'd1023;
  localparam logic       REG_LENGTH_LOG2   = 1'b0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       block_last;
    logic [9:0] read_offset;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  read_data;
    logic        launch_valid;
    logic [9:0]  launch_offset;
    logic [10:0] launch_length;
    logic [9:0]  block_accepted;
    logic [9:0]  free_space;
  } out_t;

  typedef struct packed {
    logic       clear;
    logic [3:0] length_log2;
  } cfg_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

>>> design/dtrb_ram.sv
// Single-port byte memory with a registered read port.
module dtrb_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/dtrb_cfg.sv
// APB-style configuration register holding the ring length exponent.
module dtrb_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dtrb_pkg::cfg_ctl_t cfg_ctl
);
  import dtrb_pkg::*;

  logic [3:0] length_log2_r;
  logic [3:0] length_log2_nxt;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH_LOG2);

  always_comb begin
    length_log2_nxt = length_log2_r;
    if (wr_hit) begin
      length_log2_nxt = pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_log2_r <= LENGTH_LOG2_RESET;
    end else begin
      length_log2_r <= length_log2_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_LENGTH_LOG2) ? {28'd0, length_log2_r} : 32'd0;

  assign cfg_ctl.clear       = wr_hit;
  assign cfg_ctl.length_log2 = length_log2_nxt;

endmodule

>>> design/dtrb_ctrl.sv
// Pointer, block and transfer control with the result register.
module dtrb_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dtrb_pkg::cfg_ctl_t cfg_ctl,
  input  logic               in_valid,
  output logic               in_ready,
  input  dtrb_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dtrb_pkg::out_t     out_data,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output logic [7:0]         mem_wdata,
  input  logic [7:0]         mem_rdata
);
  import dtrb_pkg::*;

  localparam int LOG_MAX = $clog2(DEPTH + 1) - 1;

  state_t        st_r, st_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [9:0]    bc_r, bc_nxt;
  logic [10:0]   infl_r, infl_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic [4:0]    ll_eff;
  logic [AW-1:0] mask;
  logic [AW:0]   len;
  logic          in_fire;
  logic [AW-1:0] free_now;
  logic [9:0]    reported;
  logic          do_launch;
  logic [AW:0]   n;
  out_t          res;

  always_comb begin
    ll_eff = {1'b0, cfg_ctl.length_log2};
    if (ll_eff < 5'd1) begin
      ll_eff = 5'd1;
    end
    if (ll_eff > 5'(LOG_MAX)) begin
      ll_eff = 5'(LOG_MAX);
    end
  end

  assign mask = ~({AW{1'b1}} << ll_eff);
  assign len  = {{AW{1'b0}}, 1'b1} << ll_eff;

  assign in_ready = (st_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    st_nxt        = st_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    bc_nxt        = bc_r;
    infl_nxt      = infl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    reported      = bc_r;
    do_launch     = 1'b0;
    n             = '0;
    free_now      = (rp_r - wp_r - AW'(1)) & mask;
    res           = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = wp_r;
    mem_wdata     = in_data.data_byte;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.cmd)
            CMD_WRITE: begin
              if (free_now != '0) begin
                mem_we       = 1'b1;
                wp_nxt       = (wp_r + AW'(1)) & mask;
                res.accepted = 1'b1;
                if (bc_r != BLOCK_COUNT_MAX) begin
                  bc_nxt = bc_r + 10'd1;
                end
              end
              reported = bc_nxt;
              if (in_data.block_last) begin
                bc_nxt = '0;
                if (infl_r == '0 && wp_nxt != rp_nxt) begin
                  do_launch = 1'b1;
                end
              end
            end
            CMD_READ: begin
              mem_re   = 1'b1;
              mem_addr = AW'(in_data.read_offset) & mask;
              st_nxt   = ST_READ;
            end
            CMD_DONE: begin
              if (infl_r != '0) begin
                rp_nxt = (rp_r + AW'(infl_r)) & mask;
                if (wp_nxt != rp_nxt) begin
                  do_launch = 1'b1;
                end else begin
                  infl_nxt = '0;
                end
              end
            end
            default: begin
            end
          endcase
          if (do_launch) begin
            if (wp_nxt > rp_nxt) begin
              n = {1'b0, wp_nxt} - {1'b0, rp_nxt};
            end else begin
              n = len - {1'b0, rp_nxt};
            end
            infl_nxt          = 11'(n);
            res.launch_valid  = 1'b1;
            res.launch_offset = 10'(rp_nxt);
            res.launch_length = 11'(n);
          end
        end
      end
      ST_READ: begin
        res.read_data = mem_rdata;
        st_nxt        = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    res.block_accepted = reported;
    res.free_space     = 10'((rp_nxt - wp_nxt - AW'(1)) & mask);
    if ((in_fire && in_data.cmd != CMD_READ) || st_r == ST_READ) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
    if (cfg_ctl.clear) begin
      wp_nxt   = '0;
      rp_nxt   = '0;
      bc_nxt   = '0;
      infl_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      bc_r        <= '0;
      infl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      bc_r        <= bc_nxt;
      infl_r      <= infl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "dma_tx_ring_buffer_assert.svh"

  `DTRB_ASSERT(a_read_slot_free, st_r == ST_READ |-> !out_valid_r, "Result slot busy on read.")
  `DTRB_ASSERT(a_read_enters_wait, in_fire && in_data.cmd == CMD_READ |=> st_r == ST_READ, "Read beat did not wait for memory.")
  `DTRB_ASSERT(a_inflight_has_data, infl_r != '0 |-> wp_r != rp_r, "Transfer running on an empty ring.")
  `DTRB_ASSERT_NEVER(a_no_busy_write, mem_we && st_r == ST_READ, "Memory written while a read is pending.")

endmodule

>>> design/dma_tx_ring_buffer.sv
// Top level of the byte ring buffer that feeds a transmit DMA.
// Write, done and unused-command beats may follow back to back while the output is drained;
// a read beat waits in ST_READ, holding off other beats, for the registered single-port ring
// memory. A result beat waits in an output register and the next input beat is taken while
// it is drained. The ring length is 2**length_log2 bytes, clamped to 1..log2(DEPTH), and one
// slot always stays empty. Writing length_log2 clears both pointers, the block count and any
// running transfer but keeps the stored bytes; no clearing pass runs after reset.
module dma_tx_ring_buffer #(
  parameter int DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtrb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dtrb_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import dtrb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cfg_ctl_t      cfg_ctl;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  dtrb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_ctl (cfg_ctl)
  );

  dtrb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ctl   (cfg_ctl),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  dtrb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
